>>> hdl/dpc_pkg.sv
// shared constants for the density point clustering block
`timescale 1ns / 1ps
`default_nettype none
package dpc_pkg;

    localparam int unsigned MAX_POINTS_DEF = 1024;
    localparam int unsigned COORD_BITS_DEF = 16;

    localparam int EPS_BITS        = 34;
    localparam int MINPTS_BITS     = 11;
    localparam int INDEX_PORT_BITS = 10;
    localparam int TOTAL_BITS      = 11;
    localparam int CFG_INDEX_BITS  = 1;

    // input item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_EPS_SQ  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_PTS = 1'b1;

endpackage
`default_nettype wire

>>> hdl/density_point_clustering.sv
// top level of the density point clustering block
`timescale 1ns / 1ps
`default_nettype none
// Density based clustering of up to MAX_POINTS 3D points. Mode 0 transactions load
// one point each, one per cycle while the result side is free; the transaction that
// carries last_point starts clustering and its result (done_res, cluster_total)
// appears after the pass. The pass first clears one per-point state entry a cycle,
// then walks points in index order; every neighbor search is a full streamed sweep
// over the point memory, done once to count neighbors and once more to queue
// neighbors of each core point, so the pass is set by that one point memory read
// port. Mode 1 transactions read one label through the label memory. Configuration
// writes are taken every cycle.
module density_point_clustering
    import dpc_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dpc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [dpc_pkg::EPS_BITS-1:0]          cfg_data,
    // input channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_mode,
    input  wire logic signed [COORD_BITS-1:0]          s_coord_x,
    input  wire logic signed [COORD_BITS-1:0]          s_coord_y,
    input  wire logic signed [COORD_BITS-1:0]          s_coord_z,
    input  wire logic                                  s_last_point,
    input  wire logic [dpc_pkg::INDEX_PORT_BITS-1:0]   s_read_index,
    // result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_done_res,
    output logic [dpc_pkg::TOTAL_BITS-1:0]             m_cluster_total,
    output logic                                       m_label_valid,
    output logic [dpc_pkg::INDEX_PORT_BITS-1:0]        m_cluster_id,
    output logic                                       m_is_noise,
    output logic                                       m_index_bad
);
    import dpc_pkg::*;

    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CB   = COORD_BITS;
    localparam int PW   = 3 * CB;
    localparam int SQW  = 2 * CB + 1;
    localparam int SUMW = SQW + 2;
    localparam int DW   = (SUMW > EPS_BITS) ? SUMW : EPS_BITS;
    localparam int NW   = (CW > MINPTS_BITS) ? CW : MINPTS_BITS;

    // per-point clustering state: mark holds cluster id + 1 of the cluster that queued or opened it
    typedef struct packed {
        logic          visited;
        logic          labeled;
        logic [IW-1:0] label;
        logic [CW-1:0] mark;
    } meta_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LABEL, ST_CLEAR, ST_P_RD, ST_P_CHK, ST_SCAN,
        ST_Q_RD, ST_Q_WAIT, ST_Q_CHK, ST_FIN
    } state_t;

    // memories
    logic [PW-1:0] point_mem [MAX_POINTS];
    meta_t         meta_mem  [MAX_POINTS];
    logic [IW-1:0] queue_mem [MAX_POINTS];

    logic [PW-1:0] pt_rd;
    meta_t         meta_rd;
    logic [IW-1:0] queue_rd;

    // control state
    state_t                  state_reg;
    logic [EPS_BITS-1:0]     eps_sq_reg;
    logic [MINPTS_BITS-1:0]  min_pts_reg;
    logic [CW-1:0]           point_count_reg;
    logic [CW-1:0]           cluster_count_reg;
    logic                    finished_reg;
    logic [CW-1:0]           clr_idx_reg;
    logic [CW-1:0]           p_reg;
    logic [CW-1:0]           cid_reg;
    logic [CW-1:0]           head_reg;
    logic [CW-1:0]           tail_reg;
    logic [CW-1:0]           scan_j_reg;
    logic [CW-1:0]           ncount_reg;
    logic                    push_reg;
    logic                    in_bfs_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    rd_bad_reg;

    // datapath registers
    logic [PW-1:0]           center_reg;
    logic [IW-1:0]           center_idx_reg;
    meta_t                   cur_meta_reg;
    logic [IW-1:0]           q_reg;
    logic [IW-1:0]           j1_reg;
    logic [IW-1:0]           j2_reg;
    logic                    self2_reg;
    meta_t                   meta2_reg;
    logic [SQW-1:0]          sqx_reg, sqy_reg, sqz_reg;

    // output registers
    logic                        m_valid_reg;
    logic                        done_res_reg;
    logic [TOTAL_BITS-1:0]       cluster_total_reg;
    logic                        label_valid_reg;
    logic [INDEX_PORT_BITS-1:0]  cluster_id_reg;
    logic                        is_noise_reg;
    logic                        index_bad_reg;

    // handshakes
    logic s_fire;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;

    // load slot: a finished set restarts at index zero
    logic [CW-1:0] load_base;
    logic          load_ok;
    logic          read_bad;
    assign load_base = finished_reg ? '0 : point_count_reg;
    assign load_ok   = 32'(load_base) < 32'(MAX_POINTS);
    assign read_bad  = 32'(s_read_index) >= 32'(point_count_reg);

    // neighbor sweep control
    logic          issue;
    logic          scan_end;
    logic [DW-1:0] dist_sum;
    logic          near;
    logic          push_hit;
    logic          is_core;
    logic [CW-1:0] cur_mark;

    assign issue    = (state_reg == ST_SCAN) && (scan_j_reg < point_count_reg);
    assign scan_end = (state_reg == ST_SCAN) && !issue && !v1_reg && !v2_reg;
    assign dist_sum = DW'(sqx_reg) + DW'(sqy_reg) + DW'(sqz_reg);
    assign near     = v2_reg && !self2_reg && (dist_sum <= DW'(eps_sq_reg));
    assign cur_mark = cid_reg + 1'b1;
    assign push_hit = near && push_reg && (meta2_reg.mark != cur_mark)
                      && (32'(tail_reg) < 32'(MAX_POINTS));
    assign is_core  = NW'(ncount_reg) >= NW'(min_pts_reg);

    // squared distance of the streamed point to the center
    logic signed [CB:0]     dx, dy, dz;
    logic signed [2*CB+1:0] px, py, pz;
    always_comb begin
        dx = $signed({pt_rd[PW-1], pt_rd[PW-1 -: CB]})
           - $signed({center_reg[PW-1], center_reg[PW-1 -: CB]});
        dy = $signed({pt_rd[2*CB-1], pt_rd[2*CB-1 -: CB]})
           - $signed({center_reg[2*CB-1], center_reg[2*CB-1 -: CB]});
        dz = $signed({pt_rd[CB-1], pt_rd[CB-1:0]})
           - $signed({center_reg[CB-1], center_reg[CB-1:0]});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    // memory read addresses
    logic [IW-1:0] rd_addr;
    always_comb begin
        unique case (state_reg)
            ST_IDLE:   rd_addr = IW'(s_read_index);
            ST_P_RD:   rd_addr = p_reg[IW-1:0];
            ST_Q_WAIT: rd_addr = queue_rd;
            ST_SCAN:   rd_addr = scan_j_reg[IW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    // label state write port
    logic          meta_we;
    logic [IW-1:0] meta_waddr;
    meta_t         meta_wdata;
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = '0;
        meta_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                meta_we    = (clr_idx_reg != point_count_reg);
                meta_waddr = clr_idx_reg[IW-1:0];
            end
            ST_SCAN: begin
                if (push_hit) begin
                    meta_we         = 1'b1;
                    meta_waddr      = j2_reg;
                    meta_wdata      = meta2_reg;
                    meta_wdata.mark = cur_mark;
                end else if (scan_end && !push_reg && !in_bfs_reg) begin
                    // outer point: mark visited, and open a cluster when core
                    meta_we            = 1'b1;
                    meta_waddr         = center_idx_reg;
                    meta_wdata         = cur_meta_reg;
                    meta_wdata.visited = 1'b1;
                    if (is_core) begin
                        meta_wdata.labeled = 1'b1;
                        meta_wdata.label   = IW'(cluster_count_reg);
                        meta_wdata.mark    = cluster_count_reg + 1'b1;
                    end
                end
            end
            ST_Q_CHK: begin
                // popped point joins the cluster unless already labeled
                meta_we            = 1'b1;
                meta_waddr         = q_reg;
                meta_wdata         = meta_rd;
                meta_wdata.visited = 1'b1;
                if (!meta_rd.labeled) begin
                    meta_wdata.labeled = 1'b1;
                    meta_wdata.label   = IW'(cid_reg);
                end
            end
            default: meta_we = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (s_fire && (s_mode == MODE_LOAD) && load_ok) begin
            point_mem[load_base[IW-1:0]] <= {s_coord_x, s_coord_y, s_coord_z};
        end
        pt_rd <= point_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd <= meta_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (push_hit) begin
            queue_mem[tail_reg[IW-1:0]] <= j2_reg;
        end
        queue_rd <= queue_mem[head_reg[IW-1:0]];
    end

    // datapath
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_P_CHK) || (state_reg == ST_Q_CHK)) begin
            center_reg <= pt_rd;
        end
        if (state_reg == ST_P_CHK) begin
            cur_meta_reg <= meta_rd;
        end
        if (state_reg == ST_Q_WAIT) begin
            q_reg <= queue_rd;
        end
        j1_reg    <= scan_j_reg[IW-1:0];
        j2_reg    <= j1_reg;
        self2_reg <= (j1_reg == center_idx_reg);
        meta2_reg <= meta_rd;
        sqx_reg   <= px[SQW-1:0];
        sqy_reg   <= py[SQW-1:0];
        sqz_reg   <= pz[SQW-1:0];
    end

    // sequencer, configuration registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            eps_sq_reg        <= '0;
            min_pts_reg       <= MINPTS_BITS'(1);
            point_count_reg   <= '0;
            cluster_count_reg <= '0;
            finished_reg      <= 1'b0;
            clr_idx_reg       <= '0;
            p_reg             <= '0;
            cid_reg           <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            scan_j_reg        <= '0;
            ncount_reg        <= '0;
            push_reg          <= 1'b0;
            in_bfs_reg        <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            rd_bad_reg        <= 1'b0;
            center_idx_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_EPS_SQ:  eps_sq_reg  <= cfg_data;
                    REG_MIN_PTS: min_pts_reg <= cfg_data[MINPTS_BITS-1:0];
                    default:     eps_sq_reg  <= eps_sq_reg;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_mode == MODE_LOAD) begin
                            if (finished_reg) begin
                                cluster_count_reg <= '0;
                                finished_reg      <= 1'b0;
                            end
                            point_count_reg <= load_ok ? load_base + 1'b1 : load_base;
                            if (s_last_point) begin
                                clr_idx_reg <= '0;
                                state_reg   <= ST_CLEAR;
                            end
                        end else begin
                            rd_bad_reg <= read_bad;
                            state_reg  <= ST_LABEL;
                        end
                    end
                end
                ST_LABEL: begin
                    m_valid_reg       <= 1'b1;
                    done_res_reg      <= finished_reg;
                    cluster_total_reg <= TOTAL_BITS'(cluster_count_reg);
                    label_valid_reg   <= 1'b1;
                    index_bad_reg     <= rd_bad_reg;
                    is_noise_reg      <= !rd_bad_reg && (!finished_reg || !meta_rd.labeled);
                    cluster_id_reg    <= (!rd_bad_reg && finished_reg && meta_rd.labeled)
                                         ? INDEX_PORT_BITS'(meta_rd.label) : '0;
                    state_reg         <= ST_IDLE;
                end
                ST_CLEAR: begin
                    if (clr_idx_reg == point_count_reg) begin
                        p_reg     <= '0;
                        state_reg <= ST_P_RD;
                    end else begin
                        clr_idx_reg <= clr_idx_reg + 1'b1;
                    end
                end
                ST_P_RD: begin
                    state_reg <= (p_reg == point_count_reg) ? ST_FIN : ST_P_CHK;
                end
                ST_P_CHK: begin
                    if (meta_rd.visited) begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_P_RD;
                    end else begin
                        center_idx_reg <= p_reg[IW-1:0];
                        in_bfs_reg     <= 1'b0;
                        push_reg       <= 1'b0;
                        scan_j_reg     <= '0;
                        ncount_reg     <= '0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) begin
                        scan_j_reg <= scan_j_reg + 1'b1;
                    end
                    if (near && !push_reg) begin
                        ncount_reg <= ncount_reg + 1'b1;
                    end
                    if (push_hit) begin
                        tail_reg <= tail_reg + 1'b1;
                    end
                    if (scan_end) begin
                        if (push_reg) begin
                            state_reg <= ST_Q_RD;
                        end else if (is_core) begin
                            push_reg   <= 1'b1;
                            scan_j_reg <= '0;
                            if (!in_bfs_reg) begin
                                cid_reg           <= cluster_count_reg;
                                cluster_count_reg <= cluster_count_reg + 1'b1;
                                head_reg          <= '0;
                                tail_reg          <= '0;
                            end
                        end else if (in_bfs_reg) begin
                            state_reg <= ST_Q_RD;
                        end else begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= ST_P_RD;
                        end
                    end
                end
                ST_Q_RD: begin
                    if (head_reg == tail_reg) begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_P_RD;
                    end else begin
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= ST_Q_WAIT;
                    end
                end
                ST_Q_WAIT: begin
                    state_reg <= ST_Q_CHK;
                end
                ST_Q_CHK: begin
                    if (!meta_rd.visited) begin
                        center_idx_reg <= q_reg;
                        in_bfs_reg     <= 1'b1;
                        push_reg       <= 1'b0;
                        scan_j_reg     <= '0;
                        ncount_reg     <= '0;
                        state_reg      <= ST_SCAN;
                    end else begin
                        state_reg <= ST_Q_RD;
                    end
                end
                ST_FIN: begin
                    finished_reg      <= 1'b1;
                    m_valid_reg       <= 1'b1;
                    done_res_reg      <= 1'b1;
                    cluster_total_reg <= TOTAL_BITS'(cluster_count_reg);
                    label_valid_reg   <= 1'b0;
                    cluster_id_reg    <= '0;
                    is_noise_reg      <= 1'b0;
                    index_bad_reg     <= 1'b0;
                    state_reg         <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_done_res      = done_res_reg;
    assign m_cluster_total = cluster_total_reg;
    assign m_label_valid   = label_valid_reg;
    assign m_cluster_id    = cluster_id_reg;
    assign m_is_noise      = is_noise_reg;
    assign m_index_bad     = index_bad_reg;

endmodule
`default_nettype wire

>>> hdl/dpc_checker.sv
// port level checks for the density point clustering block and their bind
`timescale 1ns / 1ps
`default_nettype none
module dpc_checker
    import dpc_pkg::*;
(
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic                                m_done_res,
    input wire logic [dpc_pkg::TOTAL_BITS-1:0]      m_cluster_total,
    input wire logic                                m_label_valid,
    input wire logic [dpc_pkg::INDEX_PORT_BITS-1:0] m_cluster_id,
    input wire logic                                m_is_noise,
    input wire logic                                m_index_bad
);
    import dpc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cluster_total)
        && $stable(m_label_valid))
        else $error("result changed while stalled");

    // a result that is no label read is the end of clustering
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_label_valid |-> m_done_res && m_cluster_id == '0
        && !m_is_noise && !m_index_bad)
        else $error("bad clustering result");

    // a bad index carries no label
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_bad |-> m_cluster_id == '0 && !m_is_noise)
        else $error("bad index with label");

    // noise carries no cluster id
    a_noise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_noise |-> m_cluster_id == '0)
        else $error("noise with cluster id");

endmodule

bind density_point_clustering dpc_checker u_dpc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_done_res      (m_done_res),
    .m_cluster_total (m_cluster_total),
    .m_label_valid   (m_label_valid),
    .m_cluster_id    (m_cluster_id),
    .m_is_noise      (m_is_noise),
    .m_index_bad     (m_index_bad)
);
`default_nettype wire
